>>> rtl/eulr_pkg.sv
// ----------------------------------------------------------------------------
// eulr_pkg - shared constants for the Euler point rotator
// Word widths of the CORDIC datapath and the arctangent table in phase units.
// ----------------------------------------------------------------------------
package eulr_pkg;

  // CORDIC x/y words, signed Q.28
  localparam int TRIG_W    = 32;
  localparam int TRIG_FRAC = 28;
  // residual phase, 32-bit turn plus growth headroom
  localparam int PHASE_W   = 32;
  localparam int Z_W       = 34;
  localparam int TABLE_LEN = 24;

  // 0.60725293500888 in Q.28, removes the CORDIC gain
  localparam logic [TRIG_W-1:0] CORDIC_START = 32'd163008218;

  // atan(2^-i) in units where 2^32 is a full turn
  function automatic logic [Z_W-1:0] atan_phase(input logic [4:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 34'd536870912;
      5'd1:    v = 34'd316933406;
      5'd2:    v = 34'd167458907;
      5'd3:    v = 34'd85004756;
      5'd4:    v = 34'd42667331;
      5'd5:    v = 34'd21354465;
      5'd6:    v = 34'd10679838;
      5'd7:    v = 34'd5340245;
      5'd8:    v = 34'd2670163;
      5'd9:    v = 34'd1335087;
      5'd10:   v = 34'd667544;
      5'd11:   v = 34'd333772;
      5'd12:   v = 34'd166886;
      5'd13:   v = 34'd83443;
      5'd14:   v = 34'd41722;
      5'd15:   v = 34'd20861;
      5'd16:   v = 34'd10430;
      5'd17:   v = 34'd5215;
      5'd18:   v = 34'd2608;
      5'd19:   v = 34'd1304;
      5'd20:   v = 34'd652;
      5'd21:   v = 34'd326;
      5'd22:   v = 34'd163;
      5'd23:   v = 34'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/eulr_cordic_cell.sv
// ----------------------------------------------------------------------------
// eulr_cordic_cell - one CORDIC micro-rotation for three angles
// Rotates three x/y/z triples by atan(2^-STAGE) and hands them to the next
// cell together with the side data that rides along.
// ----------------------------------------------------------------------------
module eulr_cordic_cell
  import eulr_pkg::*;
#(
  parameter int STAGE  = 0,
  parameter int PASS_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0][TRIG_W-1:0]     in_x,
  input  logic [2:0][TRIG_W-1:0]     in_y,
  input  logic [2:0][Z_W-1:0]        in_z,
  input  logic [PASS_W-1:0]          in_pass,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0][TRIG_W-1:0]     out_x,
  output logic [2:0][TRIG_W-1:0]     out_y,
  output logic [2:0][Z_W-1:0]        out_z,
  output logic [PASS_W-1:0]          out_pass
);

  localparam logic [Z_W-1:0] ATAN = atan_phase(5'(STAGE));

  logic                   valid_r;
  logic [2:0][TRIG_W-1:0] x_r, x_nxt;
  logic [2:0][TRIG_W-1:0] y_r, y_nxt;
  logic [2:0][Z_W-1:0]    z_r, z_nxt;
  logic [PASS_W-1:0]      pass_r;
  logic                   take;

  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  // rotate toward zero residual phase
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!in_z[k][Z_W-1]) begin
        x_nxt[k] = in_x[k] - TRIG_W'($signed(in_y[k]) >>> STAGE);
        y_nxt[k] = in_y[k] + TRIG_W'($signed(in_x[k]) >>> STAGE);
        z_nxt[k] = in_z[k] - ATAN;
      end else begin
        x_nxt[k] = in_x[k] + TRIG_W'($signed(in_y[k]) >>> STAGE);
        y_nxt[k] = in_y[k] - TRIG_W'($signed(in_x[k]) >>> STAGE);
        z_nxt[k] = in_z[k] + ATAN;
      end
    end
  end

  // advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // load payload
  always_ff @(posedge clk) begin
    if (take) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      pass_r <= in_pass;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_pass  = pass_r;

endmodule

>>> rtl/eulr_plane_rot.sv
// ----------------------------------------------------------------------------
// eulr_plane_rot - rotation of one coordinate pair by a cosine/sine pair
// Stage one forms the four products, stage two adds and rounds:
// a' = round(a*c + b*s), b' = round(b*c - a*s), ties toward plus infinity.
// ----------------------------------------------------------------------------
module eulr_plane_rot
  import eulr_pkg::*;
#(
  parameter int CIW    = 20,
  parameter int PASS_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CIW-1:0]    in_a,
  input  logic [CIW-1:0]    in_b,
  input  logic [TRIG_W-1:0] in_cos,
  input  logic [TRIG_W-1:0] in_sin,
  input  logic [PASS_W-1:0] in_pass,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CIW-1:0]    out_a,
  output logic [CIW-1:0]    out_b,
  output logic [PASS_W-1:0] out_pass
);

  localparam int PW = CIW + TRIG_W;
  localparam int SW = PW + 1;
  localparam logic [SW-1:0] HALF = SW'(1) << (TRIG_FRAC - 1);

  logic                 valid1_r, valid2_r;
  logic                 ready1, ready2;
  logic signed [PW-1:0] ac_r, bs_r, bc_r, as_r;
  logic [PASS_W-1:0]    pass1_r, pass2_r;
  logic [SW-1:0]        sum_a, sum_b;
  logic [CIW-1:0]       a_r, b_r;

  assign ready2   = !valid2_r || out_ready;
  assign ready1   = !valid1_r || ready2;
  assign in_ready = ready1;

  // advance valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      if (ready1) valid1_r <= in_valid;
      if (ready2) valid2_r <= valid1_r;
    end
  end

  // form products
  always_ff @(posedge clk) begin
    if (in_valid && ready1) begin
      ac_r    <= PW'($signed(in_a) * $signed(in_cos));
      bs_r    <= PW'($signed(in_b) * $signed(in_sin));
      bc_r    <= PW'($signed(in_b) * $signed(in_cos));
      as_r    <= PW'($signed(in_a) * $signed(in_sin));
      pass1_r <= in_pass;
    end
  end

  // add exactly and round
  assign sum_a = SW'(ac_r) + SW'(bs_r) + HALF;
  assign sum_b = SW'(bc_r) - SW'(as_r) + HALF;

  always_ff @(posedge clk) begin
    if (valid1_r && ready2) begin
      a_r     <= sum_a[CIW+TRIG_FRAC-1:TRIG_FRAC];
      b_r     <= sum_b[CIW+TRIG_FRAC-1:TRIG_FRAC];
      pass2_r <= pass1_r;
    end
  end

  assign out_valid = valid2_r;
  assign out_a     = a_r;
  assign out_b     = b_r;
  assign out_pass  = pass2_r;

endmodule

>>> rtl/euler_xyz_point_rotator.sv
// ----------------------------------------------------------------------------
// euler_xyz_point_rotator - rotate a point about z, then y, then x
// A chain of CORDIC cells produces three sine/cosine pairs, three plane
// rotation units apply them, and an output register clips the result.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   point_x/y/z, angle_about_x/y/z
//   out_     output     out_valid/out_stall rotated_x/y/z, saturated_flag
//
// Throughput is one transaction per cycle while out_ is not stalled; the
// pipeline registers are one per CORDIC cell, two per plane rotation, one for clipping.
// Reset clears every stage valid; payload registers are not reset.
// A stall on out_ holds the output register; upstream stages keep filling
// until the chain is full, then in_stall rises.
// ----------------------------------------------------------------------------
module euler_xyz_point_rotator
  import eulr_pkg::*;
#(
  parameter int COORD_WIDTH   = 18,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] in_point_x,
  input  logic [COORD_WIDTH-1:0] in_point_y,
  input  logic [COORD_WIDTH-1:0] in_point_z,
  input  logic [ANGLE_WIDTH-1:0] in_angle_about_x,
  input  logic [ANGLE_WIDTH-1:0] in_angle_about_y,
  input  logic [ANGLE_WIDTH-1:0] in_angle_about_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COORD_WIDTH-1:0] out_rotated_x,
  output logic [COORD_WIDTH-1:0] out_rotated_y,
  output logic [COORD_WIDTH-1:0] out_rotated_z,
  output logic                   out_saturated_flag
);

  localparam int CIW    = COORD_WIDTH + 2;
  localparam int CP_W   = 3 * CIW + 3;
  localparam int N      = CORDIC_STAGES;
  localparam logic signed [CIW-1:0] HI = CIW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [CIW-1:0] LO = -HI - CIW'(1);

  // build initial phase triples, folding quadrants two and three
  logic [2:0][ANGLE_WIDTH-1:0] angle;
  logic [2:0][TRIG_W-1:0]      x0, y0;
  logic [2:0][Z_W-1:0]         z0;
  logic [2:0]                  flip;
  logic [PHASE_W-1:0]          phase [3];

  assign angle = {in_angle_about_z, in_angle_about_y, in_angle_about_x};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      phase[k] = {angle[k], {(PHASE_W - ANGLE_WIDTH){1'b0}}};
      flip[k]  = phase[k][PHASE_W-1] ^ phase[k][PHASE_W-2];
      if (flip[k]) phase[k][PHASE_W-1] = ~phase[k][PHASE_W-1];
      z0[k] = Z_W'($signed(phase[k]));
      x0[k] = CORDIC_START;
      y0[k] = '0;
    end
  end

  // chain of CORDIC cells
  logic                   c_valid [N+1];
  logic                   c_ready [N+1];
  logic [2:0][TRIG_W-1:0] c_x     [N+1];
  logic [2:0][TRIG_W-1:0] c_y     [N+1];
  logic [2:0][Z_W-1:0]    c_z     [N+1];
  logic [CP_W-1:0]        c_pass  [N+1];

  assign c_valid[0] = in_valid;
  assign c_x[0]     = x0;
  assign c_y[0]     = y0;
  assign c_z[0]     = z0;
  assign c_pass[0]  = {flip,
                       CIW'($signed(in_point_z)),
                       CIW'($signed(in_point_y)),
                       CIW'($signed(in_point_x))};
  assign in_stall   = !c_ready[0];

  for (genvar g = 0; g < N; g++) begin : g_cell
    eulr_cordic_cell #(
      .STAGE  (g),
      .PASS_W (CP_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_valid[g]),
      .in_ready  (c_ready[g]),
      .in_x      (c_x[g]),
      .in_y      (c_y[g]),
      .in_z      (c_z[g]),
      .in_pass   (c_pass[g]),
      .out_valid (c_valid[g+1]),
      .out_ready (c_ready[g+1]),
      .out_x     (c_x[g+1]),
      .out_y     (c_y[g+1]),
      .out_z     (c_z[g+1]),
      .out_pass  (c_pass[g+1])
    );
  end

  // undo the quadrant fold: x is cosine, y is sine
  logic [2:0][TRIG_W-1:0] cosv, sinv;
  logic [2:0]             flip_n;
  logic [CIW-1:0]         px, py, pz;

  assign {flip_n, pz, py, px} = c_pass[N];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cosv[k] = flip_n[k] ? -c_x[N][k] : c_x[N][k];
      sinv[k] = flip_n[k] ? -c_y[N][k] : c_y[N][k];
    end
  end

  // rotate about z: pair (x, y)
  localparam int PZ_W = CIW + 4 * TRIG_W;
  logic            rz_valid, rz_ready;
  logic [CIW-1:0]  rz_x, rz_y;
  logic [PZ_W-1:0] rz_pass;

  eulr_plane_rot #(.CIW(CIW), .PASS_W(PZ_W)) u_rot_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid[N]),
    .in_ready  (c_ready[N]),
    .in_a      (px),
    .in_b      (py),
    .in_cos    (cosv[2]),
    .in_sin    (sinv[2]),
    .in_pass   ({pz, sinv[1], cosv[1], sinv[0], cosv[0]}),
    .out_valid (rz_valid),
    .out_ready (rz_ready),
    .out_a     (rz_x),
    .out_b     (rz_y),
    .out_pass  (rz_pass)
  );

  logic [CIW-1:0]    z1;
  logic [TRIG_W-1:0] s1y, c1y, s1x, c1x;
  assign {z1, s1y, c1y, s1x, c1x} = rz_pass;

  // rotate about y: pair (x, z)
  localparam int PY_W = CIW + 2 * TRIG_W;
  logic            ry_valid, ry_ready;
  logic [CIW-1:0]  ry_x, ry_z;
  logic [PY_W-1:0] ry_pass;

  eulr_plane_rot #(.CIW(CIW), .PASS_W(PY_W)) u_rot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rz_valid),
    .in_ready  (rz_ready),
    .in_a      (rz_x),
    .in_b      (z1),
    .in_cos    (c1y),
    .in_sin    (s1y),
    .in_pass   ({rz_y, s1x, c1x}),
    .out_valid (ry_valid),
    .out_ready (ry_ready),
    .out_a     (ry_x),
    .out_b     (ry_z),
    .out_pass  (ry_pass)
  );

  logic [CIW-1:0]    y2;
  logic [TRIG_W-1:0] s2x, c2x;
  assign {y2, s2x, c2x} = ry_pass;

  // rotate about x: pair (y, z)
  logic           rx_valid, rx_ready;
  logic [CIW-1:0] rx_y, rx_z, rx_x;

  eulr_plane_rot #(.CIW(CIW), .PASS_W(CIW)) u_rot_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ry_valid),
    .in_ready  (ry_ready),
    .in_a      (y2),
    .in_b      (ry_z),
    .in_cos    (c2x),
    .in_sin    (s2x),
    .in_pass   (ry_x),
    .out_valid (rx_valid),
    .out_ready (rx_ready),
    .out_a     (rx_y),
    .out_b     (rx_z),
    .out_pass  (rx_x)
  );

  // clip to the coordinate range and register the result
  logic [2:0][CIW-1:0]         fin;
  logic [2:0][COORD_WIDTH-1:0] clip_v;
  logic [2:0]                  clip_f;
  logic                        out_valid_r;
  logic [COORD_WIDTH-1:0]      rx_r, ry_r, rz_r;
  logic                        sat_r;

  assign fin = {rx_z, rx_y, rx_x};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if ($signed(fin[k]) > HI) begin
        clip_v[k] = HI[COORD_WIDTH-1:0];
        clip_f[k] = 1'b1;
      end else if ($signed(fin[k]) < LO) begin
        clip_v[k] = LO[COORD_WIDTH-1:0];
        clip_f[k] = 1'b1;
      end else begin
        clip_v[k] = fin[k][COORD_WIDTH-1:0];
        clip_f[k] = 1'b0;
      end
    end
  end

  assign rx_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rx_ready) begin
      out_valid_r <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      rx_r  <= clip_v[0];
      ry_r  <= clip_v[1];
      rz_r  <= clip_v[2];
      sat_r <= |clip_f;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_rotated_x      = rx_r;
  assign out_rotated_y      = ry_r;
  assign out_rotated_z      = rz_r;
  assign out_saturated_flag = sat_r;

  // input stalls only when the whole chain backs up from a held output
  a_stall_from_output : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output stage is free");

  // a clipped transaction carries at least one extreme coordinate
  a_sat_extreme : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated_flag) |->
      (out_rotated_x == HI[COORD_WIDTH-1:0] || out_rotated_x == LO[COORD_WIDTH-1:0] ||
       out_rotated_y == HI[COORD_WIDTH-1:0] || out_rotated_y == LO[COORD_WIDTH-1:0] ||
       out_rotated_z == HI[COORD_WIDTH-1:0] || out_rotated_z == LO[COORD_WIDTH-1:0]))
    else $error("saturation flag without clipped coordinate");

  // reset empties the output stage
  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
